FILE: src/wspc_pkg.sv
// Package with widths, constants and register codes of the windowed PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

package wspc_pkg;

    localparam int TARGET_W = 10;
    localparam int MEAS_W   = 12;
    localparam int GAIN_W   = 10;
    localparam int REV_W    = 9;
    localparam int THR_W    = 12;
    localparam int DRIVE_W  = 27;
    localparam int AIM_W    = 17;
    localparam int ERR_W    = 18;
    localparam int DIFF_W   = ERR_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int HISTORY_DEPTH_DEFAULT = 9;

    localparam logic [AIM_W-1:0] STOP_AIM = AIM_W'(99999);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(67108863);

    localparam logic [GAIN_W-1:0]       GAIN_P_RESET  = GAIN_W'(300);
    localparam logic [GAIN_W-1:0]       GAIN_D_RESET  = GAIN_W'(2);
    localparam logic [GAIN_W-1:0]       GAIN_I_RESET  = GAIN_W'(8);
    localparam logic signed [REV_W-1:0] REVERSE_RESET = -REV_W'(50);
    localparam logic [THR_W-1:0]        THRESH_RESET  = THR_W'(5);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_PROPORTIONAL    = 3'd0,
        CFG_GAIN_DERIVATIVE      = 3'd1,
        CFG_GAIN_INTEGRAL        = 3'd2,
        CFG_REVERSE_DRIVE        = 3'd3,
        CFG_STOP_SPEED_THRESHOLD = 3'd4
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: src/wspc_sample_if.sv
// Interface of the input channel that carries one control tick.
`timescale 1ns / 1ps
`default_nettype none

interface wspc_sample_if;

    logic                          valid;
    logic                          ready;
    logic [wspc_pkg::TARGET_W-1:0] target_speed;
    logic                          stop_request;
    logic [wspc_pkg::MEAS_W-1:0]   measured_speed;

    modport source (
        output valid,
        output target_speed,
        output stop_request,
        output measured_speed,
        input  ready
    );

    modport sink (
        input  valid,
        input  target_speed,
        input  stop_request,
        input  measured_speed,
        output ready
    );

endinterface

`default_nettype wire

FILE: src/wspc_result_if.sv
// Interface of the output channel that carries one drive command.
`timescale 1ns / 1ps
`default_nettype none

interface wspc_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [wspc_pkg::DRIVE_W-1:0] drive_value;
    logic                                braking;

    modport source (
        output valid,
        output drive_value,
        output braking,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive_value,
        input  braking,
        output ready
    );

endinterface

`default_nettype wire

FILE: src/windowed_pid_speed_controller.sv
// Top level of the windowed PID speed controller.
//
// Each transfer on the sample channel carries a target speed, a stop request and a
// measured speed; each one yields exactly one transfer on the result channel with the
// drive command and the braking flag, in order.
// The past errors sit in a chain of HISTORY_DEPTH cells that shift on every accepted
// sample, and a running sum of the chain gives the window integral without an adder tree.
// The pipeline has three register stages: error terms, gain products, and the
// saturated output register. A sample's result passes through all three in order, and one
// sample can be accepted in every cycle while the receiver keeps taking results.
// Each stage has its own valid bit, so a sample is still taken while a finished result
// waits; when the receiver stalls, the stages fill up and the sample channel drops ready
// only once all three are occupied. Nothing is lost while stalled.
// The gain and brake registers are written through the plain configuration port and
// must only change while no sample is in flight.
// Reset clears the error history, the running sum and all valid bits, and loads the
// default gains, reverse drive and threshold; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module windowed_pid_speed_controller #(
    parameter int HISTORY_DEPTH = wspc_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    wspc_sample_if.sink                             sample,
    wspc_result_if.source                           result,
    input  wire logic                               cfg_write_en,
    input  wire logic [wspc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wspc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ERR_W   = wspc_pkg::ERR_W;
    localparam int DIFF_W  = wspc_pkg::DIFF_W;
    localparam int WIN_W   = ERR_W + $clog2(HISTORY_DEPTH + 1);
    localparam int GS_W    = wspc_pkg::GAIN_W + 1;
    localparam int PP_W    = GS_W + ERR_W;
    localparam int PD_W    = GS_W + DIFF_W;
    localparam int PI_W    = GS_W + WIN_W;
    localparam int SUM_W   = PI_W + 2;
    localparam int DRIVE_W = wspc_pkg::DRIVE_W;

    // Configuration registers.
    logic [wspc_pkg::GAIN_W-1:0]       gain_p_reg;
    logic [wspc_pkg::GAIN_W-1:0]       gain_d_reg;
    logic [wspc_pkg::GAIN_W-1:0]       gain_i_reg;
    logic signed [wspc_pkg::REV_W-1:0] reverse_reg;
    logic [wspc_pkg::THR_W-1:0]        thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= wspc_pkg::GAIN_P_RESET;
            gain_d_reg  <= wspc_pkg::GAIN_D_RESET;
            gain_i_reg  <= wspc_pkg::GAIN_I_RESET;
            reverse_reg <= wspc_pkg::REVERSE_RESET;
            thresh_reg  <= wspc_pkg::THRESH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                wspc_pkg::CFG_GAIN_PROPORTIONAL:
                    gain_p_reg <= cfg_data[wspc_pkg::GAIN_W-1:0];
                wspc_pkg::CFG_GAIN_DERIVATIVE:
                    gain_d_reg <= cfg_data[wspc_pkg::GAIN_W-1:0];
                wspc_pkg::CFG_GAIN_INTEGRAL:
                    gain_i_reg <= cfg_data[wspc_pkg::GAIN_W-1:0];
                wspc_pkg::CFG_REVERSE_DRIVE:
                    reverse_reg <= cfg_data[wspc_pkg::REV_W-1:0];
                wspc_pkg::CFG_STOP_SPEED_THRESHOLD:
                    thresh_reg <= cfg_data[wspc_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake of the three stages.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic accept;

    assign s3_ready     = !out_valid_reg || result.ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample.ready = s1_ready;
    assign accept       = sample.valid && s1_ready;

    // Error history chain.
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] tap [HISTORY_DEPTH];

    genvar k;
    generate
        for (k = 0; k < HISTORY_DEPTH; k++)
        begin : g_chain
            if (k == 0)
            begin : g_head
                wspc_cell #(.WIDTH(ERR_W)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .d        (err),
                    .q        (tap[k])
                );
            end
            else
            begin : g_body
                wspc_cell #(.WIDTH(ERR_W)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .d        (tap[k-1]),
                    .q        (tap[k])
                );
            end
        end
    endgenerate

    // Stage one: error, change and window sum.
    logic [wspc_pkg::AIM_W-1:0] aim;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [WIN_W-1:0]    window;
    logic signed [WIN_W-1:0]    hist_sum_reg;
    logic signed [WIN_W-1:0]    hist_sum_next;

    assign aim = sample.stop_request ? wspc_pkg::STOP_AIM
                                     : wspc_pkg::AIM_W'(sample.target_speed);
    assign err = $signed({1'b0, aim}) - $signed(ERR_W'(sample.measured_speed));
    assign diff = DIFF_W'(err) - DIFF_W'(tap[0]);
    assign window = hist_sum_reg + WIN_W'(err);
    assign hist_sum_next = accept ? (window - WIN_W'(tap[HISTORY_DEPTH-1])) : hist_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_sum_reg <= '0;
        end
        else
        begin
            hist_sum_reg <= hist_sum_next;
        end
    end

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [WIN_W-1:0]  win_reg;
    logic                     s1_stop_reg;
    logic                     s1_slow_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg     <= err;
            diff_reg    <= diff;
            win_reg     <= window;
            s1_stop_reg <= sample.stop_request;
            s1_slow_reg <= sample.measured_speed < thresh_reg;
        end
    end

    // Stage two: gain products.
    logic signed [PP_W-1:0] prod_p_reg;
    logic signed [PD_W-1:0] prod_d_reg;
    logic signed [PI_W-1:0] prod_i_reg;
    logic                   s2_stop_reg;
    logic                   s2_slow_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            prod_p_reg  <= PP_W'($signed({1'b0, gain_p_reg})) * PP_W'(err_reg);
            prod_d_reg  <= PD_W'($signed({1'b0, gain_d_reg})) * PD_W'(diff_reg);
            prod_i_reg  <= PI_W'($signed({1'b0, gain_i_reg})) * PI_W'(win_reg);
            s2_stop_reg <= s1_stop_reg;
            s2_slow_reg <= s1_slow_reg;
        end
    end

    // Stage three: sum, clamp and brake selection.
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      braking_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      braking_reg;

    assign pid_sum = SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg) + SUM_W'(prod_i_reg);

    always_comb
    begin
        braking_next = 1'b0;
        priority if (s2_stop_reg && s2_slow_reg)
        begin
            drive_next = '0;
        end
        else if (s2_stop_reg)
        begin
            drive_next   = DRIVE_W'(reverse_reg);
            braking_next = 1'b1;
        end
        else if (pid_sum <= SUM_W'(0))
        begin
            drive_next = '0;
        end
        else if (pid_sum > SUM_W'(wspc_pkg::DRIVE_MAX))
        begin
            drive_next = wspc_pkg::DRIVE_MAX;
        end
        else
        begin
            drive_next = pid_sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            drive_reg   <= drive_next;
            braking_reg <= braking_next;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_value = drive_reg;
    assign result.braking     = braking_reg;

endmodule

`default_nettype wire

FILE: src/wspc_cell.sv
// One cell of the error history chain: holds one past error and passes it on each transfer.
`timescale 1ns / 1ps
`default_nettype none

module wspc_cell #(
    parameter int WIDTH = wspc_pkg::ERR_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift_en,
    input  wire logic signed [WIDTH-1:0] d,
    output      logic signed [WIDTH-1:0] q
);

    logic signed [WIDTH-1:0] q_reg;
    logic signed [WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift_en)
        begin
            q_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: dv/wspc_tb_pkg.sv
// Scoreboard class that predicts and checks the drive commands of the speed controller.
`timescale 1ns / 1ps

package wspc_tb_pkg;

    import wspc_pkg::*;

    localparam int WINDOW_DEPTH = HISTORY_DEPTH_DEFAULT;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive_value;
        logic                      braking;
    } drive_cmd_t;

    class pid_drive_tracker;

        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_d;
        logic [GAIN_W-1:0]       gain_i;
        logic signed [REV_W-1:0] reverse;
        logic [THR_W-1:0]        threshold;
        longint                  error_hist [WINDOW_DEPTH];
        drive_cmd_t              pending_drives [$];
        int                      mismatches;
        int                      checked;
        int                      saturated;
        int                      braked;

        function new();
            gain_p     = GAIN_P_RESET;
            gain_d     = GAIN_D_RESET;
            gain_i     = GAIN_I_RESET;
            reverse    = REVERSE_RESET;
            threshold  = THRESH_RESET;
            foreach (error_hist[k])
                error_hist[k] = 0;
            mismatches = 0;
            checked    = 0;
            saturated  = 0;
            braked     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_GAIN_PROPORTIONAL:    gain_p    = data[GAIN_W-1:0];
                CFG_GAIN_DERIVATIVE:      gain_d    = data[GAIN_W-1:0];
                CFG_GAIN_INTEGRAL:        gain_i    = data[GAIN_W-1:0];
                CFG_REVERSE_DRIVE:        reverse   = data[REV_W-1:0];
                CFG_STOP_SPEED_THRESHOLD: threshold = data[THR_W-1:0];
                default:                  ;
            endcase
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction

        // Works out the drive command for one accepted tick and shifts the error window.
        function void note_tick(logic [TARGET_W-1:0] target, logic stop,
                                logic [MEAS_W-1:0] meas);
            longint     aim;
            longint     err;
            longint     change;
            longint     window;
            longint     sum;
            drive_cmd_t cmd;
            int         k;
            aim    = stop ? longint'(STOP_AIM) : longint'(target);
            err    = aim - longint'(meas);
            change = err - error_hist[0];
            window = err;
            for (k = 0; k < WINDOW_DEPTH; k++)
                window += error_hist[k];
            sum = longint'(gain_p) * err + longint'(gain_d) * change
                + longint'(gain_i) * window;
            for (k = WINDOW_DEPTH - 1; k > 0; k--)
                error_hist[k] = error_hist[k - 1];
            error_hist[0] = err;

            cmd.braking = 1'b0;
            if (sum <= 0)
                cmd.drive_value = '0;
            else if (sum >= longint'(DRIVE_MAX))
                cmd.drive_value = DRIVE_MAX;
            else
                cmd.drive_value = sum[DRIVE_W-1:0];

            if (stop)
            begin
                if (meas < threshold)
                begin
                    cmd.drive_value = '0;
                end
                else
                begin
                    cmd.drive_value = reverse;
                    cmd.braking     = 1'b1;
                    braked++;
                end
            end
            else if (sum >= longint'(DRIVE_MAX))
            begin
                saturated++;
            end
            pending_drives.push_back(cmd);
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] drive, logic brake);
            drive_cmd_t want;
            checked++;
            if (pending_drives.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer drive=%0d braking=%b",
                                          drive, brake));
                return;
            end
            want = pending_drives.pop_front();
            if (drive !== want.drive_value || brake !== want.braking)
                report_mismatch($sformatf(
                    "expected drive=%0d braking=%b, got drive=%0d braking=%b",
                    want.drive_value, want.braking, drive, brake));
        endfunction

    endclass

endpackage

FILE: dv/tb_top.sv
// Testbench top that drives random and directed control ticks into the speed controller.
`timescale 1ns / 1ps

module tb_top;

    import wspc_pkg::*;
    import wspc_tb_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int GAP_MAX         = 18;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int LONG_HOLD       = 80;
    localparam int TAIL_CYCLES     = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wspc_sample_if sample ();
    wspc_result_if result ();

    pid_drive_tracker tracker;
    int               sender_gap_max;
    int               receiver_gap_max;
    int               hold_cycles;
    int               idle_count;
    int               ticks_sent;
    int               settings_used;
    int               stop_run;

    windowed_pid_speed_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
                tracker.note_tick(sample.target_speed, sample.stop_request,
                                  sample.measured_speed);
            if (result.valid && result.ready)
                tracker.check_drive(result.drive_value, result.braking);
            if ((sample.valid && sample.ready) || (result.valid && result.ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_tick(input int target, input int stop, input int meas);
        int gap;
        gap = $urandom_range(sender_gap_max, 0);
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid          <= 1'b1;
        sample.target_speed   <= TARGET_W'(target);
        sample.stop_request   <= 1'(stop);
        sample.measured_speed <= MEAS_W'(meas);
        do @(posedge clk); while (!sample.ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Stop requests mostly come in runs, so that the error window fills with large values.
    task automatic send_random_tick();
        int target;
        int stop;
        int meas;
        int pick;
        if (stop_run == 0 && $urandom_range(11, 0) == 0)
            stop_run = $urandom_range(12, 1);
        stop = (stop_run > 0) ? 1 : 0;
        if (stop_run > 0)
            stop_run--;
        else if ($urandom_range(19, 0) == 0)
            stop = 1;
        pick = $urandom_range(7, 0);
        if (pick == 0)
            target = 0;
        else if (pick == 1)
            target = 1023;
        else
            target = $urandom_range(1023, 0);
        pick = $urandom_range(7, 0);
        if (pick == 0)
        begin
            meas = 0;
        end
        else if (pick == 1)
        begin
            meas = 4095;
        end
        else if (pick <= 3)
        begin
            meas = int'(tracker.threshold) + int'($urandom_range(2, 0)) - 1;
            if (meas < 0)
                meas = 0;
            if (meas > 4095)
                meas = 4095;
        end
        else
        begin
            meas = $urandom_range(4095, 0);
        end
        send_tick(target, stop, meas);
    endtask

    task automatic wait_drained();
        sample.valid <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        tracker.set_register(index, data);
        @(negedge clk);
    endtask

    task automatic configure(input int gp, input int gd, input int gi,
                             input int rev, input int thr);
        write_register(CFG_GAIN_PROPORTIONAL, CFG_DATA_W'(gp));
        write_register(CFG_GAIN_DERIVATIVE, CFG_DATA_W'(gd));
        write_register(CFG_GAIN_INTEGRAL, CFG_DATA_W'(gi));
        write_register(CFG_REVERSE_DRIVE, CFG_DATA_W'(rev));
        write_register(CFG_STOP_SPEED_THRESHOLD, CFG_DATA_W'(thr));
        write_register(CFG_INDEX_W'(int'(CFG_STOP_SPEED_THRESHOLD) + 1
                                    + int'($urandom_range(2, 0))),
                       CFG_DATA_W'($urandom));
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : receiver
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(receiver_gap_max, 0);
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        int item;
        tracker               = new();
        rst_n                 = 1'b0;
        cfg_write_en          = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sample.valid          = 1'b0;
        sample.target_speed   = '0;
        sample.stop_request   = 1'b0;
        sample.measured_speed = '0;
        result.ready          = 1'b0;
        sender_gap_max        = GAP_MAX;
        receiver_gap_max      = GAP_MAX;
        hold_cycles           = 0;
        idle_count            = 0;
        ticks_sent            = 0;
        settings_used         = 1;
        stop_run              = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default gains: zero and negative sums, braking at and around the threshold.
        send_tick(0, 0, 0);
        send_tick(0, 0, 4095);
        send_tick(1023, 0, 0);
        send_tick(1023, 0, 0);
        send_tick(0, 1, 4095);
        send_tick(0, 1, 5);
        send_tick(0, 1, 4);
        send_tick(1023, 1, 0);
        send_tick(1023, 0, 0);
        send_tick(512, 0, 512);

        // Full gains drive the sum into saturation; braking with a zero reverse drive.
        wait_drained();
        configure(1023, 1023, 1023, 0, 4095);
        send_tick(0, 1, 4095);
        send_tick(0, 1, 4094);
        send_tick(1023, 1, 0);
        send_tick(1023, 1, 0);
        send_tick(1023, 1, 0);
        send_tick(1023, 0, 0);
        send_tick(1023, 0, 4095);

        wait_drained();
        configure(0, 0, 0, -255, 0);
        send_tick(1023, 0, 0);
        send_tick(0, 1, 0);

        wait_drained();
        configure(0, 0, 1023, 255, 2048);
        send_tick(0, 1, 2048);
        send_tick(0, 1, 2047);
        send_tick(700, 0, 100);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0: configure($urandom, $urandom, $urandom, $urandom, $urandom);
                1: configure(1023, 1023, 1023, $urandom_range(1, 0) ? 255 : -255,
                             $urandom_range(1, 0) ? 4095 : 0);
                2: configure(0, $urandom, 0, $urandom, $urandom_range(40, 0));
                default: configure(GAIN_P_RESET, GAIN_D_RESET, GAIN_I_RESET,
                                   REVERSE_RESET, THRESH_RESET);
            endcase
            sender_gap_max   = (phase % 3 == 1 || phase == 4) ? 0 : GAP_MAX;
            receiver_gap_max = (phase % 3 == 2 || phase == 4) ? 0 : GAP_MAX;
            // The receiver holds off while ticks keep coming, so the pipeline fills.
            if (phase == 1)
                hold_cycles = LONG_HOLD;
            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                if (phase == 3 && item == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random_tick();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("%0d control ticks sent, %0d drive commands checked, %0d gain settings.",
                 ticks_sent, tracker.checked, settings_used);
        $display("%0d braking commands and %0d saturated drives among them, %0d mismatches.",
                 tracker.braked, tracker.saturated, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
